// ===== rtl/lcabl_pkg.sv =====
// Shared types and constants for the rerooted LCA binary-lifting block.
package lcabl_pkg;

    localparam int NODE_W          = 10;
    localparam int DEPTH_W         = 10;
    localparam int LEVEL_W         = 4;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int LIFT_LEVELS_DEF = 10;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INS_RD_DEP,
        ST_INS_WR0,
        ST_INS_RD,
        ST_INS_WR,
        ST_L_DU,
        ST_L_DV,
        ST_L_SW,
        ST_L_UP,
        ST_L_UPW,
        ST_L_EQ,
        ST_L_DN,
        ST_L_DN2,
        ST_L_DN3,
        ST_L_FIN,
        ST_L_FIN2,
        ST_R_D,
        ST_R_D2
    } state_t;

    typedef struct packed {
        logic               anc_re;
        logic               anc_we;
        logic [NODE_W-1:0]  anc_node;
        logic [LEVEL_W-1:0] anc_level;
        logic [NODE_W-1:0]  anc_wdata;
        logic               dep_re;
        logic               dep_we;
        logic [NODE_W-1:0]  dep_node;
        logic [DEPTH_W-1:0] dep_wdata;
    } mem_req_t;

endpackage

// ===== rtl/rerooted_lca_binary_lifting_top.sv =====
// Top level of the rerooted LCA block: control sequencer and result register.
//
// The block keeps a binary-lifting ancestor table and a depth store in two
// single-port synchronous memories; every memory read is registered and its
// data is used by a later state. An insert transaction (s_func = 0) reads the
// parent's depth, writes the new node's depth and level-0 parent, then reads
// and writes one table entry for each higher level, and produces no result.
// A query transaction (s_func = 1) runs three LCA searches one after another.
// Each search reads both depths, lifts the deeper node level by level and,
// unless the two nodes already meet, searches downward level by level and
// fetches the final parent; it then reads the depth of its result. The last
// result waits until the output register is free. A finished result waits in
// the output register while the next transaction is taken. Node 0 is the
// sentinel above the root and always reads as zero; no clearing pass runs
// after reset. Parents must be inserted before their children, and rows of
// never-inserted nodes must not be read.
module rerooted_lca_binary_lifting_top
    import lcabl_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [NODE_W-1:0]  s_new_node,
    input  logic [NODE_W-1:0]  s_parent_node,
    input  logic [NODE_W-1:0]  s_query_x,
    input  logic [NODE_W-1:0]  s_query_y,
    input  logic [NODE_W-1:0]  s_query_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [NODE_W-1:0]  m_answer_node,
    output logic [DEPTH_W-1:0] m_answer_depth
);

    localparam int KW = $clog2(LIFT_LEVELS + 1);
    localparam logic [KW-1:0] K_LAST = KW'(LIFT_LEVELS - 1);
    localparam logic [KW-1:0] K_END  = KW'(LIFT_LEVELS);

    state_t state_reg, state_next;

    logic [NODE_W-1:0]  x_reg, y_reg, z_reg;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [NODE_W-1:0]  u_reg, u_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [NODE_W-1:0]  au_reg, au_next;
    logic [NODE_W-1:0]  res_reg, res_next;
    logic [DEPTH_W-1:0] du_reg, du_next;
    logic [DEPTH_W-1:0] gap_reg, gap_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [1:0]         pair_reg, pair_next;
    logic [NODE_W-1:0]  best_node_reg, best_node_next;
    logic [DEPTH_W-1:0] best_depth_reg, best_depth_next;
    logic               m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]  m_node_reg, m_node_next;
    logic [DEPTH_W-1:0] m_depth_reg, m_depth_next;

    mem_req_t           mreq;
    logic [NODE_W-1:0]  anc_rdata;
    logic [DEPTH_W-1:0] dep_rdata;

    logic               s_fire;
    logic               ins_ok;
    logic [NODE_W-1:0]  pair_a, pair_b;
    logic               gap_bit;
    logic               cand_wins;
    logic               out_free;
    logic [NODE_W-1:0]  fin_node;
    logic [DEPTH_W-1:0] fin_depth;

    lcabl_store #(
        .MAX_NODES   (MAX_NODES),
        .LIFT_LEVELS (LIFT_LEVELS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mreq),
        .anc_rdata (anc_rdata),
        .dep_rdata (dep_rdata)
    );

    assign s_fire = s_valid && s_ready;
    // drop inserts of the sentinel and of nodes past the store
    assign ins_ok = (s_new_node != '0) &&
                    ({{(32-NODE_W){1'b0}}, s_new_node} < 32'(MAX_NODES));

    // pairs in tie order: (x,y), (x,z), (y,z)
    assign pair_a = (pair_reg == 2'd2) ? y_reg : x_reg;
    assign pair_b = (pair_reg == 2'd0) ? y_reg : z_reg;

    // gap bits at or above the level count are ignored
    assign gap_bit = ((gap_reg >> k_reg) & DEPTH_W'(1)) != '0;

    assign cand_wins = (pair_reg == 2'd0) || (dep_rdata > best_depth_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign fin_node  = cand_wins ? res_reg   : best_node_reg;
    assign fin_depth = cand_wins ? dep_rdata : best_depth_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_func == FUNC_QUERY) state_next = ST_L_DU;
                    else if (ins_ok)          state_next = ST_INS_RD_DEP;
                end
            end
            ST_INS_RD_DEP: state_next = ST_INS_WR0;
            ST_INS_WR0:    state_next = ST_INS_RD;
            ST_INS_RD:     state_next = ST_INS_WR;
            ST_INS_WR:     state_next = (k_reg == K_LAST) ? ST_IDLE : ST_INS_RD;
            ST_L_DU:       state_next = ST_L_DV;
            ST_L_DV:       state_next = ST_L_SW;
            ST_L_SW:       state_next = ST_L_UP;
            ST_L_UP: begin
                if (k_reg == K_END) state_next = ST_L_EQ;
                else if (gap_bit)   state_next = ST_L_UPW;
            end
            ST_L_UPW:      state_next = ST_L_UP;
            ST_L_EQ:       state_next = (u_reg == v_reg) ? ST_R_D : ST_L_DN;
            ST_L_DN:       state_next = ST_L_DN2;
            ST_L_DN2:      state_next = ST_L_DN3;
            ST_L_DN3:      state_next = (k_reg == '0) ? ST_L_FIN : ST_L_DN;
            ST_L_FIN:      state_next = ST_L_FIN2;
            ST_L_FIN2:     state_next = ST_R_D;
            ST_R_D:        state_next = ST_R_D2;
            ST_R_D2: begin
                if (pair_reg != 2'd2) state_next = ST_L_DU;
                else if (out_free)    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory requests
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        mreq    = '0;
        case (state_reg)
            ST_INS_RD_DEP: begin
                mreq.dep_re   = 1'b1;
                mreq.dep_node = v_reg;
            end
            ST_INS_WR0: begin
                mreq.dep_we    = 1'b1;
                mreq.dep_node  = node_reg;
                mreq.dep_wdata = (v_reg == '0) ? '0 : dep_rdata + DEPTH_W'(1);
                mreq.anc_we    = 1'b1;
                mreq.anc_node  = node_reg;
                mreq.anc_wdata = v_reg;
            end
            ST_INS_RD: begin
                mreq.anc_re    = 1'b1;
                mreq.anc_node  = u_reg;
                mreq.anc_level = LEVEL_W'(k_reg - KW'(1));
            end
            ST_INS_WR: begin
                mreq.anc_we    = 1'b1;
                mreq.anc_node  = node_reg;
                mreq.anc_level = LEVEL_W'(k_reg);
                mreq.anc_wdata = anc_rdata;
            end
            ST_L_DU: begin
                mreq.dep_re   = 1'b1;
                mreq.dep_node = pair_a;
            end
            ST_L_DV: begin
                mreq.dep_re   = 1'b1;
                mreq.dep_node = v_reg;
            end
            ST_L_UP: begin
                mreq.anc_re    = (k_reg != K_END) && gap_bit;
                mreq.anc_node  = u_reg;
                mreq.anc_level = LEVEL_W'(k_reg);
            end
            ST_L_DN: begin
                mreq.anc_re    = 1'b1;
                mreq.anc_node  = u_reg;
                mreq.anc_level = LEVEL_W'(k_reg);
            end
            ST_L_DN2: begin
                mreq.anc_re    = 1'b1;
                mreq.anc_node  = v_reg;
                mreq.anc_level = LEVEL_W'(k_reg);
            end
            ST_L_FIN: begin
                mreq.anc_re   = 1'b1;
                mreq.anc_node = u_reg;
            end
            ST_R_D: begin
                mreq.dep_re   = 1'b1;
                mreq.dep_node = res_reg;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb begin
        node_next       = node_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        au_next         = au_reg;
        res_next        = res_reg;
        du_next         = du_reg;
        gap_next        = gap_reg;
        k_next          = k_reg;
        pair_next       = pair_reg;
        best_node_next  = best_node_reg;
        best_depth_next = best_depth_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_node_next     = m_node_reg;
        m_depth_next    = m_depth_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    node_next = s_new_node;
                    v_next    = s_parent_node;
                    pair_next = 2'd0;
                end
            end
            ST_INS_WR0: begin
                u_next = v_reg;
                k_next = KW'(1);
            end
            ST_INS_WR: begin
                u_next = anc_rdata;
                k_next = k_reg + KW'(1);
            end
            ST_L_DU: begin
                u_next = pair_a;
                v_next = pair_b;
            end
            ST_L_DV: du_next = dep_rdata;
            ST_L_SW: begin
                k_next = '0;
                if (du_reg < dep_rdata) begin
                    u_next   = v_reg;
                    v_next   = u_reg;
                    gap_next = dep_rdata - du_reg;
                end else begin
                    gap_next = du_reg - dep_rdata;
                end
            end
            ST_L_UP: begin
                if (k_reg != K_END && !gap_bit) k_next = k_reg + KW'(1);
            end
            ST_L_UPW: begin
                u_next = anc_rdata;
                k_next = k_reg + KW'(1);
            end
            ST_L_EQ: begin
                res_next = u_reg;
                k_next   = K_LAST;
            end
            ST_L_DN2: au_next = anc_rdata;
            ST_L_DN3: begin
                if (au_reg != anc_rdata) begin
                    u_next = au_reg;
                    v_next = anc_rdata;
                end
                if (k_reg != '0) k_next = k_reg - KW'(1);
            end
            ST_L_FIN2: res_next = anc_rdata;
            ST_R_D2: begin
                if (pair_reg != 2'd2) begin
                    best_node_next  = fin_node;
                    best_depth_next = fin_depth;
                    pair_next       = pair_reg + 2'd1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_node_next  = fin_node;
                    m_depth_next = fin_depth;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            pair_reg    <= 2'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
            pair_reg    <= pair_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg <= s_query_x;
            y_reg <= s_query_y;
            z_reg <= s_query_z;
        end
        node_reg       <= node_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        au_reg         <= au_next;
        res_reg        <= res_next;
        du_reg         <= du_next;
        gap_reg        <= gap_next;
        best_node_reg  <= best_node_next;
        best_depth_reg <= best_depth_next;
        m_node_reg     <= m_node_next;
        m_depth_reg    <= m_depth_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_answer_node  = m_node_reg;
    assign m_answer_depth = m_depth_reg;

    // The sentinel row is never written.
    a_no_sentinel_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.anc_we |-> mreq.anc_node != '0)
        else $error("ancestor write to sentinel node");

    // Level counter never exceeds the number of lifting levels.
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_END)
        else $error("level counter out of range");

    // Only three pairs are searched per query.
    a_pair_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_reg != 2'd3)
        else $error("pair index out of range");

    // An insert never raises a result.
    a_insert_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_func == FUNC_INSERT |=> !$rose(m_valid_reg))
        else $error("result raised after insert");

endmodule

// ===== rtl/lcabl_store.sv =====
// Ancestor table and depth store with registered, sentinel-masked reads.
module lcabl_store
    import lcabl_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mem_req_t           req,
    output logic [NODE_W-1:0]  anc_rdata,
    output logic [DEPTH_W-1:0] dep_rdata
);

    localparam int AW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW        = $clog2(LIFT_LEVELS);
    localparam int ANC_DEPTH = MAX_NODES * (2 ** LW);

    logic [NODE_W-1:0]  anc_mem [0:ANC_DEPTH-1];
    logic [DEPTH_W-1:0] dep_mem [0:MAX_NODES-1];

    logic [NODE_W-1:0]  anc_rd_reg;
    logic [DEPTH_W-1:0] dep_rd_reg;
    logic               anc_ok_reg;
    logic               dep_ok_reg;

    logic anc_ok;
    logic dep_ok;
    logic [AW+LW-1:0] anc_addr;

    // node 0 is the sentinel and reads as zero; nodes past the store read as zero
    assign anc_ok = (req.anc_node != '0) &&
                    ({{(32-NODE_W){1'b0}}, req.anc_node} < 32'(MAX_NODES));
    assign dep_ok = (req.dep_node != '0) &&
                    ({{(32-NODE_W){1'b0}}, req.dep_node} < 32'(MAX_NODES));
    assign anc_addr = {AW'(req.anc_node), LW'(req.anc_level)};

    always_ff @(posedge aclk) begin
        if (req.anc_we && anc_ok) begin
            anc_mem[anc_addr] <= req.anc_wdata;
        end
        if (req.anc_re) begin
            anc_rd_reg <= anc_mem[anc_addr];
        end
        if (req.dep_we && dep_ok) begin
            dep_mem[AW'(req.dep_node)] <= req.dep_wdata;
        end
        if (req.dep_re) begin
            dep_rd_reg <= dep_mem[AW'(req.dep_node)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            anc_ok_reg <= 1'b0;
            dep_ok_reg <= 1'b0;
        end else begin
            if (req.anc_re) anc_ok_reg <= anc_ok;
            if (req.dep_re) dep_ok_reg <= dep_ok;
        end
    end

    assign anc_rdata = anc_ok_reg ? anc_rd_reg : '0;
    assign dep_rdata = dep_ok_reg ? dep_rd_reg : '0;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the rerooted LCA binary-lifting block.
`timescale 1ns / 1ps

module tb;
    import lcabl_pkg::*;

    localparam int  CLK_HALF     = 10;
    localparam int  LEVELS       = LIFT_LEVELS_DEF;
    localparam int  NODES        = MAX_NODES_DEF;
    localparam int  CYCLE_LIMIT  = 2_000_000;
    localparam int  DRAIN_WAIT   = 400;
    localparam int  FOREST_ITEMS = 130;
    localparam int  CHAIN_LEN    = 360;

    typedef struct {
        logic              func;
        logic [NODE_W-1:0] new_node;
        logic [NODE_W-1:0] parent_node;
        logic [NODE_W-1:0] qx;
        logic [NODE_W-1:0] qy;
        logic [NODE_W-1:0] qz;
    } lca_req_t;

    typedef struct {
        logic [NODE_W-1:0]  node;
        logic [DEPTH_W-1:0] depth;
    } lca_answer_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic [NODE_W-1:0]  s_new_node;
    logic [NODE_W-1:0]  s_parent_node;
    logic [NODE_W-1:0]  s_query_x;
    logic [NODE_W-1:0]  s_query_y;
    logic [NODE_W-1:0]  s_query_z;
    logic               m_valid;
    logic               m_ready;
    logic [NODE_W-1:0]  m_answer_node;
    logic [DEPTH_W-1:0] m_answer_depth;

    // Shadow copy of the block's tree: lifting table and depth per node.
    logic [NODE_W-1:0]  lift_tbl [NODES][LEVELS];
    logic [DEPTH_W-1:0] depth_of [NODES];

    lca_answer_t answers_due[$];
    int          present_nodes[$];    // ids whose rows have been written
    int          fail_count;
    int          cycle_count;
    int          burst_left;
    int          ready_pct;

    rerooted_lca_binary_lifting_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_new_node     (s_new_node),
        .s_parent_node  (s_parent_node),
        .s_query_x      (s_query_x),
        .s_query_y      (s_query_y),
        .s_query_z      (s_query_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_answer_node  (m_answer_node),
        .m_answer_depth (m_answer_depth)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Plain LCA in the original rooting: lift the deeper node, then descend.
    function automatic logic [NODE_W-1:0] plain_lca(logic [NODE_W-1:0] a,
                                                    logic [NODE_W-1:0] b);
        logic [NODE_W-1:0]  u;
        logic [NODE_W-1:0]  v;
        logic [NODE_W-1:0]  t;
        logic [DEPTH_W-1:0] gap;
        u = a;
        v = b;
        if (depth_of[u] < depth_of[v]) begin
            t = u; u = v; v = t;
        end
        gap = depth_of[u] - depth_of[v];
        for (int k = 0; k < LEVELS; k++) begin
            if (gap[k])
                u = lift_tbl[u][k];
        end
        if (u == v)
            return u;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            if (lift_tbl[u][k] != lift_tbl[v][k]) begin
                u = lift_tbl[u][k];
                v = lift_tbl[v][k];
            end
        end
        return lift_tbl[u][0];
    endfunction

    // Update the shadow tree for an insert, or queue the rerooted answer.
    task automatic apply_transaction(input lca_req_t req);
        logic [NODE_W-1:0] l1;
        logic [NODE_W-1:0] l2;
        logic [NODE_W-1:0] l3;
        lca_answer_t       ans;
        if (req.func == FUNC_INSERT) begin
            if (req.new_node != 0) begin
                depth_of[req.new_node] = (req.parent_node == 0) ? '0
                                       : depth_of[req.parent_node] + 1'b1;
                lift_tbl[req.new_node][0] = req.parent_node;
                for (int k = 1; k < LEVELS; k++)
                    lift_tbl[req.new_node][k] =
                        lift_tbl[lift_tbl[req.new_node][k-1]][k-1];
            end
        end else begin
            l1 = plain_lca(req.qx, req.qy);
            l2 = plain_lca(req.qx, req.qz);
            l3 = plain_lca(req.qy, req.qz);
            // ties go to LCA(x,y), then LCA(x,z)
            if (depth_of[l1] >= depth_of[l2] && depth_of[l1] >= depth_of[l3])
                ans.node = l1;
            else if (depth_of[l2] >= depth_of[l3])
                ans.node = l2;
            else
                ans.node = l3;
            ans.depth = depth_of[ans.node];
            answers_due = {answers_due, ans};
        end
    endtask

    // Send one transaction, with bursts and random gaps between them.
    task automatic send_item(input lca_req_t req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_func        <= req.func;
        s_new_node    <= req.new_node;
        s_parent_node <= req.parent_node;
        s_query_x     <= req.qx;
        s_query_y     <= req.qy;
        s_query_z     <= req.qz;
        do @(posedge aclk); while (!s_ready);
        apply_transaction(req);
    endtask

    // Random don't-care fields keep every bit of every port moving.
    function automatic lca_req_t rand_req();
        lca_req_t r;
        r.func        = FUNC_INSERT;
        r.new_node    = NODE_W'($urandom);
        r.parent_node = NODE_W'($urandom);
        r.qx          = NODE_W'($urandom);
        r.qy          = NODE_W'($urandom);
        r.qz          = NODE_W'($urandom);
        return r;
    endfunction

    task automatic send_insert(input int node, input int parent);
        lca_req_t r;
        r = rand_req();
        r.func        = FUNC_INSERT;
        r.new_node    = NODE_W'(node);
        r.parent_node = NODE_W'(parent);
        send_item(r);
        if (node != 0)
            present_nodes = {present_nodes, node};
    endtask

    task automatic send_query(input int x, input int y, input int z);
        lca_req_t r;
        r = rand_req();
        r.func = FUNC_QUERY;
        r.qx   = NODE_W'(x);
        r.qy   = NODE_W'(y);
        r.qz   = NODE_W'(z);
        send_item(r);
    endtask

    // Mostly a written node, now and then the sentinel.
    function automatic int pick_present();
        if ($urandom_range(0, 19) == 0)
            return 0;
        return present_nodes[$urandom_range(0, present_nodes.size() - 1)];
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
    endtask

    // Directed: sentinel insert, extreme ids, self parent, ties, node 0.
    task automatic test_directed();
        send_insert(1, 0);
        send_insert(0, 1023);
        send_insert(1023, 1);
        send_insert(512, 1023);
        send_insert(2, 512);
        send_insert(341, 2);
        send_insert(682, 1023);
        send_query(2, 682, 1);
        send_query(2, 682, 341);
        send_query(341, 341, 1);
        send_query(0, 0, 0);
        send_query(0, 2, 682);
        send_query(1023, 1023, 1023);
        send_query(2, 1, 0);
        send_query(682, 341, 2);
        send_insert(341, 341);
        send_query(341, 682, 1);
        send_query(341, 2, 341);
        send_insert(1022, 0);
        send_query(1022, 341, 682);
    endtask

    // Random forest growing parent-first, interleaved with queries.
    task automatic test_random_forest();
        int node;
        for (int i = 0; i < FOREST_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 40) begin
                node = $urandom_range(1, 1023);
                if ($urandom_range(0, 19) == 0)
                    send_insert(node, 0);
                else
                    send_insert(node, pick_present());
            end else begin
                send_query(pick_present(), pick_present(), pick_present());
            end
        end
    endtask

    // Long chain of shuffled ids: depth gaps that use the upper lifting levels.
    task automatic test_deep_chain();
        int order[1023];
        int j;
        int t;
        for (int i = 0; i < 1023; i++)
            order[i] = i + 1;
        for (int i = 1022; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i]; order[i] = order[j]; order[j] = t;
        end
        send_insert(order[0], 0);
        for (int i = 1; i < CHAIN_LEN; i++)
            send_insert(order[i], order[i-1]);
        send_query(order[0], order[CHAIN_LEN-1], order[CHAIN_LEN/2]);
        send_query(order[CHAIN_LEN-1], order[CHAIN_LEN-2], order[0]);
        for (int i = 0; i < 40; i++)
            send_query(order[$urandom_range(0, CHAIN_LEN-1)],
                       order[$urandom_range(0, CHAIN_LEN-1)],
                       order[$urandom_range(0, CHAIN_LEN-1)]);
        // self parent on the deepest node: its depth grows by one each time
        send_insert(order[CHAIN_LEN-1], order[CHAIN_LEN-1]);
        send_query(order[CHAIN_LEN-1], order[3], order[0]);
        send_insert(order[CHAIN_LEN-1], order[CHAIN_LEN-1]);
        send_query(order[CHAIN_LEN-1], order[(CHAIN_LEN*2)/3], order[CHAIN_LEN-1]);
        send_query(order[5], order[CHAIN_LEN-1], 0);
    endtask

    // Receiver: check every accepted result against the oldest expectation,
    // and stall at random with a readiness level that is itself redrawn.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected result: node %0d depth %0d",
                       m_answer_node, m_answer_depth);
                fail_count++;
            end else begin
                if (m_answer_node !== answers_due[0].node) begin
                    $error("answer_node: expected %0d, got %0d",
                           answers_due[0].node, m_answer_node);
                    fail_count++;
                end
                if (m_answer_depth !== answers_due[0].depth) begin
                    $error("answer_depth: expected %0d, got %0d",
                           answers_due[0].depth, m_answer_depth);
                    fail_count++;
                end
                void'(answers_due.pop_front());
            end
        end
        if (cycle_count % 64 == 0)
            ready_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
        m_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Watchdog: abandon the run at a generous cycle limit.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        fail_count  = 0;
        cycle_count = 0;
        burst_left  = 0;
        ready_pct   = 100;
        for (int n = 0; n < NODES; n++) begin
            depth_of[n] = '0;
            for (int k = 0; k < LEVELS; k++)
                lift_tbl[n][k] = '0;
        end
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_func        <= FUNC_INSERT;
        s_new_node    <= '0;
        s_parent_node <= '0;
        s_query_x     <= '0;
        s_query_y     <= '0;
        s_query_z     <= '0;
        m_ready       <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_forest();
        // hold the sender until every pending answer has come back
        wait_drained();
        test_deep_chain();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
